[rtl/srr_pkg.sv]
// Shared types and codes for the selective-repeat receiver.
// Depends on nothing; used by selective_repeat_receiver.
package srr_pkg;

	localparam int SEQ_W  = 3;
	localparam int WORD_W = 64;
	localparam int PAD_W  = 5;

	// result kind codes carried on m_tuser
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// input tdata, highest field first
	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [WORD_W-1:0] payload;
		logic [SEQ_W-1:0]  seq_number;
	} in_data_t;

	// output tdata, highest field first
	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [WORD_W-1:0] data_word;
		logic [SEQ_W-1:0]  ack_number;
	} out_data_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACK  = 4'b0010,
		ST_READ = 4'b0100,
		ST_DLV  = 4'b1000
	} state_t;

endpackage

[rtl/srr_slot_store.sv]
// Payload memory of the receive slots: one write port, one read port,
// registered read data. Depends on nothing.
module srr_slot_store #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/selective_repeat_receiver.sv]
// Selective-repeat ARQ receiver, top level.
// Depends on srr_pkg and srr_slot_store.
//
// Packets arrive on the s_ stream, one item each. A packet whose checksum
// flag is clear is taken and dropped. A good packet yields an ACK item
// carrying its sequence number; if the number falls in the receive window
// its payload goes into its slot if that slot is empty, and if it equals
// the window base the block then delivers stored payloads in order,
// clearing each slot and advancing the base, up to WINDOW deliveries. The
// final item of each packet's results has m_tlast set. One packet is
// handled at a time. Each delivery has two steps because of the payload
// memory: its read is issued in ST_READ and its registered data is put on
// the output register in the following ST_DLV, once that register is free.
// Filled flags live in flip-flops and clear at reset; payload memory needs
// no clearing, since a slot is read only after it has been written.
module selective_repeat_receiver #(
	parameter int SEQ_SPACE     = 8,
	parameter int WINDOW        = 4,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input packets
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // seq_number[2:0], payload[66:3], zero fill
	input  logic [0:0]  s_tuser,   // checksum_ok[0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // ack_number[2:0], data_word[66:3], zero fill
	output logic [0:0]  m_tuser,   // kind[0]
	output logic        m_tlast
);

	localparam int IDX_W = $clog2(SEQ_SPACE);
	// wide enough for sequence numbers, distances and WINDOW itself
	localparam int DW    = ((IDX_W > srr_pkg::SEQ_W) ? IDX_W : srr_pkg::SEQ_W) + 3;
	localparam int CW    = $clog2(WINDOW + 1);

	srr_pkg::state_t state_q;

	srr_pkg::in_data_t  in_data;
	srr_pkg::out_data_t out_data_q;

	logic [srr_pkg::SEQ_W-1:0] seq_q;
	logic [PAYLOAD_WIDTH-1:0]  word_q;
	logic                      inwin_q;
	logic [IDX_W-1:0]          base_q;
	logic [CW-1:0]             cnt_q;
	logic [SEQ_SPACE-1:0]      filled_q;

	logic m_valid_q;
	logic m_kind_q;
	logic m_last_q;

	logic [DW-1:0]            seq_in_w;
	logic [DW-1:0]            base_w;
	logic [DW-1:0]            seq_off;
	logic                     in_win;
	logic [IDX_W-1:0]         seq_idx;
	logic                     deliver;
	logic                     out_free;
	logic                     out_load;
	logic [IDX_W-1:0]         base_next;
	logic                     dlv_last;
	logic                     wr_en;
	logic                     rd_en;
	logic [PAYLOAD_WIDTH-1:0] rd_data;

	assign in_data = s_tdata;

	// window test on the arriving sequence number against the current base
	always_comb begin
		seq_in_w = DW'(in_data.seq_number);
		base_w   = DW'(base_q);
		if (seq_in_w >= base_w) begin
			seq_off = seq_in_w - base_w;
		end else begin
			seq_off = seq_in_w + DW'(SEQ_SPACE) - base_w;
		end
		in_win = (seq_in_w < DW'(SEQ_SPACE)) && (seq_off < DW'(WINDOW));
	end

	// slot index of the held packet; only meaningful when it is in the window
	assign seq_idx  = IDX_W'(DW'(seq_q));
	assign deliver  = inwin_q && (seq_idx == base_q);
	assign out_free = !m_valid_q || m_tready;
	// load the output register with an ACK or a delivery
	assign out_load = out_free
		&& ((state_q == srr_pkg::ST_ACK) || (state_q == srr_pkg::ST_DLV));

	assign base_next = (base_q == IDX_W'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;
	// run ends at the window limit or at the first empty slot
	assign dlv_last  = (cnt_q == CW'(WINDOW - 1)) || !filled_q[base_next];

	assign s_tready = (state_q == srr_pkg::ST_IDLE);
	assign wr_en    = (state_q == srr_pkg::ST_ACK) && out_free && inwin_q
		&& !filled_q[seq_idx];
	assign rd_en    = (state_q == srr_pkg::ST_READ);

	srr_slot_store #(
		.DEPTH(SEQ_SPACE),
		.WIDTH(PAYLOAD_WIDTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(seq_idx),
		.wr_data(word_q),
		.rd_en  (rd_en),
		.rd_addr(base_q),
		.rd_data(rd_data)
	);

	// hold the accepted packet while its results go out
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			seq_q   <= in_data.seq_number;
			word_q  <= in_data.payload[PAYLOAD_WIDTH-1:0];
			inwin_q <= in_win;
		end
	end

	// control: sequencer, window base, filled flags, output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srr_pkg::ST_IDLE;
			base_q    <= '0;
			cnt_q     <= '0;
			filled_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				srr_pkg::ST_IDLE: begin
					// drop packets with a bad checksum right here
					if (s_tvalid && s_tuser[0]) begin
						state_q <= srr_pkg::ST_ACK;
					end
				end
				srr_pkg::ST_ACK: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						cnt_q     <= '0;
						if (wr_en) begin
							filled_q[seq_idx] <= 1'b1;
						end
						// a packet at the base always leaves its slot filled
						state_q <= deliver ? srr_pkg::ST_READ : srr_pkg::ST_IDLE;
					end
				end
				srr_pkg::ST_READ: begin
					state_q <= srr_pkg::ST_DLV;
				end
				srr_pkg::ST_DLV: begin
					if (out_free) begin
						m_valid_q        <= 1'b1;
						filled_q[base_q] <= 1'b0;
						base_q           <= base_next;
						cnt_q            <= cnt_q + 1'b1;
						state_q <= dlv_last ? srr_pkg::ST_IDLE : srr_pkg::ST_READ;
					end
				end
				default: begin
					state_q <= srr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && (state_q == srr_pkg::ST_ACK)) begin
			out_data_q.pad        <= '0;
			out_data_q.data_word  <= '0;
			out_data_q.ack_number <= seq_q;
			m_kind_q              <= srr_pkg::KIND_ACK;
			m_last_q              <= !deliver;
		end else if (out_free && (state_q == srr_pkg::ST_DLV)) begin
			out_data_q.pad        <= '0;
			out_data_q.data_word  <= srr_pkg::WORD_W'(rd_data);
			out_data_q.ack_number <= '0;
			m_kind_q              <= srr_pkg::KIND_DATA;
			m_last_q              <= dlv_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule
